/* design/stable_priority_queue_top_assert.svh */
// Assertion macros for the stable priority queue.
// Used by stable_priority_queue_top; expects clk and arst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while in reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/spq_pkg.sv */
// Shared types and constants of the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue_top.
package spq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int PAYLOAD_BITS  = 32;
	localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [PRIORITY_BITS-1:0]  new_prio;
		logic [PAYLOAD_BITS-1:0]   new_payload;
	} cell_ctrl_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [PRIORITY_BITS-1:0] entry_priority;
		logic [PAYLOAD_BITS-1:0]  entry_payload;
	} req_item_t;

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] removed_payload;
		logic [1:0]              status;
		logic                    queue_empty;
		logic [COUNT_BITS-1:0]   entry_count;
	} rsp_item_t;

endpackage

/* design/spq_cell.sv */
// One slot of the sorted chain: holds a priority and a payload.
// Depends on spq_pkg for the control struct and widths.
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctrl_t               ctrl,
	input  logic                              occupied,
	input  logic                              left_ge,
	input  logic [spq_pkg::PRIORITY_BITS-1:0] left_prio,
	input  logic [spq_pkg::PAYLOAD_BITS-1:0]  left_payload,
	input  logic [spq_pkg::PRIORITY_BITS-1:0] right_prio,
	input  logic [spq_pkg::PAYLOAD_BITS-1:0]  right_payload,
	output logic [spq_pkg::PRIORITY_BITS-1:0] prio,
	output logic [spq_pkg::PAYLOAD_BITS-1:0]  payload,
	output logic                              ge
);

	logic [spq_pkg::PRIORITY_BITS-1:0] prio_q;
	logic [spq_pkg::PAYLOAD_BITS-1:0]  payload_q;

	// entry stays put on insert when it ranks equal or higher (keeps arrival order)
	assign ge      = occupied && (prio_q >= ctrl.new_prio);
	assign prio    = prio_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			spq_pkg::CELL_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						prio_q    <= ctrl.new_prio;
						payload_q <= ctrl.new_payload;
					end else begin
						prio_q    <= left_prio;
						payload_q <= left_payload;
					end
				end
			end
			spq_pkg::CELL_REMOVE: begin
				prio_q    <= right_prio;
				payload_q <= right_payload;
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/stable_priority_queue_top.sv */
// Stable priority queue: a chain of QUEUE_DEPTH cells kept sorted, head in cell 0.
// The result is registered at the edge that accepts the request.
// Throughput 1 item per cycle while no stall holds the request; the cells shift, load or hold together.
// A request is stalled only while a registered result waits to be taken.
// Reset clears the count and the result valid; slot contents stay undefined.
// Depends on spq_pkg, spq_cell and stable_priority_queue_top_assert.svh.
`include "stable_priority_queue_top_assert.svh"

module stable_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  spq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_item_t rsp
);

	localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
	localparam int CB    = spq_pkg::COUNT_BITS;

	logic [CB-1:0] count_q;
	logic [CB-1:0] count_next;
	logic          rsp_valid_q;
	spq_pkg::rsp_item_t rsp_q;
	spq_pkg::rsp_item_t rsp_next;
	spq_pkg::cell_ctrl_t ctrl;
	logic          acc;
	logic          full;
	logic          empty;
	logic          ins_ok;

	logic [spq_pkg::PRIORITY_BITS-1:0] cell_prio    [DEPTH];
	logic [spq_pkg::PAYLOAD_BITS-1:0]  cell_payload [DEPTH];
	logic [DEPTH-1:0]                  cell_ge;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign full      = (count_q == CB'(DEPTH));
	assign empty     = (count_q == '0);
	assign ins_ok    = acc && (req.req_type == spq_pkg::REQ_INSERT) && !full;

	always_comb begin
		ctrl.op          = spq_pkg::CELL_HOLD;
		ctrl.new_prio    = req.entry_priority;
		ctrl.new_payload = req.entry_payload;
		count_next       = count_q;
		rsp_next.removed_payload = '0;
		rsp_next.status  = spq_pkg::ST_OK;
		case (req.req_type)
			spq_pkg::REQ_INSERT: begin
				if (full) begin
					rsp_next.status = spq_pkg::ST_FULL;
				end else begin
					ctrl.op    = spq_pkg::CELL_INSERT;
					count_next = count_q + CB'(1);
				end
			end
			spq_pkg::REQ_REMOVE: begin
				if (empty) begin
					rsp_next.status = spq_pkg::ST_EMPTY;
				end else begin
					ctrl.op    = spq_pkg::CELL_REMOVE;
					count_next = count_q - CB'(1);
					rsp_next.removed_payload = cell_payload[0];
				end
			end
			spq_pkg::REQ_CLEAR: begin
				count_next = '0;
			end
			default: begin
			end
		endcase
		if (!acc) begin
			ctrl.op = spq_pkg::CELL_HOLD;
		end
		rsp_next.queue_empty = (count_next == '0);
		rsp_next.entry_count = count_next;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                              l_ge;
			logic [spq_pkg::PRIORITY_BITS-1:0] l_prio;
			logic [spq_pkg::PAYLOAD_BITS-1:0]  l_payload;
			logic [spq_pkg::PRIORITY_BITS-1:0] r_prio;
			logic [spq_pkg::PAYLOAD_BITS-1:0]  r_payload;

			if (gi == 0) begin : g_head
				// nothing ranks above the head
				assign l_ge      = 1'b1;
				assign l_prio    = '0;
				assign l_payload = '0;
			end else begin : g_body
				assign l_ge      = cell_ge[gi-1];
				assign l_prio    = cell_prio[gi-1];
				assign l_payload = cell_payload[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign r_prio    = '0;
				assign r_payload = '0;
			end else begin : g_inner
				assign r_prio    = cell_prio[gi+1];
				assign r_payload = cell_payload[gi+1];
			end

			spq_cell u_cell (
				.clk           (clk),
				.ctrl          (ctrl),
				.occupied      (count_q > CB'(gi)),
				.left_ge       (l_ge),
				.left_prio     (l_prio),
				.left_payload  (l_payload),
				.right_prio    (r_prio),
				.right_payload (r_payload),
				.prio          (cell_prio[gi]),
				.payload       (cell_payload[gi]),
				.ge            (cell_ge[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SPQ_ASSERT_NOW(a_count_range, 1'b1, count_q <= CB'(DEPTH), "count above depth")
	`SPQ_ASSERT_NEXT(a_insert_count, ins_ok, count_q == $past(count_q) + CB'(1), "count not bumped")
	`SPQ_ASSERT_NEXT(a_rsp_count, acc, rsp_valid && rsp.entry_count == count_q, "bad result count")
	`SPQ_ASSERT_NOW(a_rsp_empty, rsp_valid, rsp.queue_empty == (rsp.entry_count == '0), "bad empty")
	`SPQ_ASSERT_NOW(a_head_sorted, count_q >= CB'(2), cell_prio[0] >= cell_prio[1], "head order")

endmodule
